// ----- rtl/mobf_pkg.sv -----
package mobf_pkg;

    // Sequencer states of the factoring engine
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } mobf_state_t;

    // Two's complement codes of the result
    localparam logic signed [1:0] MU_ZERO = 2'sb00;
    localparam logic signed [1:0] MU_POS  = 2'sb01;
    localparam logic signed [1:0] MU_NEG  = 2'sb11;

    // First trial divisor
    localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// ----- rtl/mobf_divider.sv -----
module mobf_divider #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS:0]   trial;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        rem_shift  = {rem_reg, quot_reg[VALUE_BITS-1]};
        trial      = rem_shift - {1'b0, divisor};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        if (start)
        begin
            count_next = CNT_BITS'(VALUE_BITS);
            rem_next   = '0;
            quot_next  = dividend;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_BITS'(1));
            if (!trial[VALUE_BITS])
            begin
                rem_next  = trial[VALUE_BITS-1:0];
                quot_next = {quot_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[VALUE_BITS-1:0];
                quot_next = {quot_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/moebius_function.sv -----
// Moebius value by trial division, one item at a time.
// Sequence: input 0 goes from idle straight to finish, where done strobes; inputs 1, 2
// and 3 pass one check first; otherwise each check that passes starts a trial division, up to
// sqrt(value) + log2(value) trials in all.
// A new item is taken only from idle; busy stays high through the done strobe.
// Reset (rst_n low, asynchronous) returns the engine to idle with no result pending.
module moebius_function #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_BITS-1:0]  value,
    output logic                   done,
    output logic signed [1:0]      mu
);

    localparam int unsigned SQ_BITS = 2 * VALUE_BITS;

    mobf_pkg::mobf_state_t state_reg, state_next;

    // Working registers of the factoring loop
    logic [VALUE_BITS-1:0] work_reg, work_next;       // part not yet factored
    logic [VALUE_BITS-1:0] divisor_reg, divisor_next; // current trial divisor
    logic [SQ_BITS-1:0]    square_reg, square_next;   // divisor squared, kept incrementally
    logic [VALUE_BITS-1:0] last_reg, last_next;       // last prime found, zero for none
    logic                  parity_reg, parity_next;   // parity of the prime count
    logic                  repeat_reg, repeat_next;   // some prime showed up twice

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [VALUE_BITS-1:0] div_rem;

    // Iterative divider: one quotient bit per cycle
    mobf_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (work_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer: check divisor^2 <= work, divide, take a factor or advance
    always_comb
    begin
        state_next   = state_reg;
        work_next    = work_reg;
        divisor_next = divisor_reg;
        square_next  = square_reg;
        last_next    = last_reg;
        parity_next  = parity_reg;
        repeat_next  = repeat_reg;
        div_start    = 1'b0;
        busy         = (state_reg != mobf_pkg::ST_IDLE);
        done         = 1'b0;
        mu           = mobf_pkg::MU_ZERO;

        case (state_reg)
            mobf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // Load a fresh item; zero is divisible by every square
                    work_next    = value;
                    divisor_next = VALUE_BITS'(mobf_pkg::FIRST_DIVISOR);
                    square_next  = SQ_BITS'(mobf_pkg::FIRST_DIVISOR * mobf_pkg::FIRST_DIVISOR);
                    last_next    = '0;
                    parity_next  = 1'b0;
                    repeat_next  = (value == '0);
                    state_next   = (value == '0) ? mobf_pkg::ST_FINISH : mobf_pkg::ST_CHECK;
                end
            end

            mobf_pkg::ST_CHECK:
            begin
                if (square_reg <= {{VALUE_BITS{1'b0}}, work_reg})
                begin
                    div_start  = 1'b1;
                    state_next = mobf_pkg::ST_DIVIDE;
                end
                else
                begin
                    // What is left above one is itself a prime factor
                    if (work_reg > VALUE_BITS'(1))
                    begin
                        if (work_reg == last_reg)
                        begin
                            repeat_next = 1'b1;
                        end
                        last_next   = work_reg;
                        parity_next = ~parity_reg;
                        work_next   = VALUE_BITS'(1);
                    end
                    state_next = mobf_pkg::ST_FINISH;
                end
            end

            mobf_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        // Divisor is a prime factor: drop it from the work value
                        work_next = div_quot;
                        if (divisor_reg == last_reg)
                        begin
                            repeat_next = 1'b1;
                        end
                        last_next   = divisor_reg;
                        parity_next = ~parity_reg;
                    end
                    else
                    begin
                        // Advance: (d+1)^2 = d^2 + 2d + 1
                        divisor_next = divisor_reg + 1'b1;
                        square_next  = square_reg
                                     + SQ_BITS'({divisor_reg, 1'b1});
                    end
                    state_next = mobf_pkg::ST_CHECK;
                end
            end

            mobf_pkg::ST_FINISH:
            begin
                // Present the result for exactly one cycle
                done = 1'b1;
                if (repeat_reg)
                begin
                    mu = mobf_pkg::MU_ZERO;
                end
                else if (parity_reg)
                begin
                    mu = mobf_pkg::MU_NEG;
                end
                else
                begin
                    mu = mobf_pkg::MU_POS;
                end
                state_next = mobf_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mobf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mobf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers carry no reset; each item loads them
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        divisor_reg <= divisor_next;
        square_reg  <= square_next;
        last_reg    <= last_next;
        parity_reg  <= parity_next;
        repeat_reg  <= repeat_next;
    end

endmodule

// ----- dv/mobf_checker.sv -----
module mobf_checker #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  done,
    input  logic signed [1:0]     mu,
    output int                    errors,
    output int                    outstanding
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] arg;
        logic signed [1:0]     mu;
    } mu_entry_t;

    mu_entry_t pending_mu[$];
    mu_entry_t head;
    mu_entry_t fresh;

    // Factor by rising trial divisors; flag a prime that matches the previous one.
    function automatic logic signed [1:0] moebius_of(input logic [VALUE_BITS-1:0] n);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned prev_prime;
        bit              odd_count;
        bit              repeated;
        rest       = n;
        divisor    = mobf_pkg::FIRST_DIVISOR;
        prev_prime = 0;
        odd_count  = 1'b0;
        repeated   = 1'b0;
        if (rest == 0)
            return mobf_pkg::MU_ZERO;
        while (divisor * divisor <= rest)
        begin
            if (rest % divisor == 0)
            begin
                rest = rest / divisor;
                if (divisor == prev_prime)
                    repeated = 1'b1;
                prev_prime = divisor;
                odd_count  = ~odd_count;
            end
            else
                divisor++;
        end
        if (rest > 1)
        begin
            if (rest == prev_prime)
                repeated = 1'b1;
            odd_count = ~odd_count;
        end
        if (repeated)
            return mobf_pkg::MU_ZERO;
        return odd_count ? mobf_pkg::MU_NEG : mobf_pkg::MU_POS;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_mu.size() == 0)
                begin
                    $display("%0t: result mu=%0d with no transfer outstanding", $time, mu);
                    errors <= errors + 1;
                end
                else
                begin
                    head = pending_mu.pop_front();
                    if (mu !== head.mu)
                    begin
                        $display("%0t: mu for value %0d: expected %0d, actual %0d",
                                 $time, head.arg, head.mu, mu);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                fresh.arg = value;
                fresh.mu  = moebius_of(value);
                pending_mu.push_back(fresh);
            end
            outstanding <= pending_mu.size();
        end
    end

endmodule

// ----- dv/tb_moebius_function.sv -----
module tb_moebius_function;

    localparam int unsigned VALUE_BITS = 16;
    localparam int unsigned MAX_VALUE  = (1 << VALUE_BITS) - 1;
    localparam int unsigned RANDOM_ITEMS = 106;

    // Building blocks for well-formed products
    localparam int unsigned SMALL_PRIMES [16] =
        '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic                  done;
    logic signed [1:0]     mu;
    int                    errors;
    int                    outstanding;
    bit                    burst;

    moebius_function #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .value (value),
        .done  (done),
        .mu    (mu)
    );

    // The checker watches both channels and keeps the expected mu queue.
    mobf_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .done        (done),
        .mu          (mu),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, set for the slowest run of about 130 items.
    initial
    begin
        #80_000_000;
        $display("FAIL");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Favor products of small primes so both the squarefree and the
    // repeated-factor paths are hit often; keep most values small to keep
    // the trial-division run short.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned roll;
        int unsigned product;
        int unsigned prime;
        int unsigned count;
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            product = 1;
            count   = $urandom_range(1, 5);
            repeat (count)
            begin
                prime = SMALL_PRIMES[$urandom_range(0, 15)];
                if (product * prime <= MAX_VALUE)
                    product = product * prime;
                // square the factor now and then
                if ($urandom_range(0, 3) == 0 && product * prime <= MAX_VALUE)
                    product = product * prime;
            end
            return product[VALUE_BITS-1:0];
        end
        if (roll < 7)
            return VALUE_BITS'($urandom_range(1, 2047));
        if (roll < 9)
            return VALUE_BITS'($urandom_range(0, MAX_VALUE));
        prime   = SMALL_PRIMES[$urandom_range(0, 15)];
        product = prime * prime * $urandom_range(1, MAX_VALUE / (prime * prime));
        return product[VALUE_BITS-1:0];
    endfunction

    // Hold start high until the block takes the transfer.
    task automatic send_value(input logic [VALUE_BITS-1:0] arg);
        value <= arg;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for a random gap after the transfer.
    task automatic idle_sender();
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned directed [$];
        int unsigned settle;
        directed = '{
            0,                   // zero: every square divides it
            1,                   // no prime factors
            2, 3, 5,             // small primes; 2 and 3 need no division
            4, 8, 49, 961,       // prime powers
            6, 30, 210, 2310, 30030,
            255, 42,
            32768,               // largest power of two
            16129, 63001, 64009, // squares of larger numbers
            64507,               // two large primes
            65534, MAX_VALUE,
            65521                // largest prime: slowest search
        };

        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        burst = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_value(VALUE_BITS'(directed[i]));
            idle_sender();
        end

        // Let the block go fully idle before the random part.
        drain();

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Switch between stretches with and without idling.
            if (n % 10 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_value(pick_value());
            if ($urandom_range(0, 29) == 0)
                drain();
            else
                idle_sender();
        end

        drain();
        settle = 100;
        repeat (settle) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
